// ===== rtl/tccs_pkg.sv =====
// tccs_pkg: shared types and constants for the text console block
// controller/datapath command and status structs, mode and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

  localparam int MAX_ROWS_DEF    = 32;
  localparam int MAX_COLUMNS_DEF = 128;

  // stream payload widths, data fields padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 1'b1;
  localparam logic [5:0] SCREEN_ROWS_RESET    = 6'd25;
  localparam logic [7:0] SCREEN_COLUMNS_RESET = 8'd80;

  // item modes
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  typedef struct packed {
    logic load;       // latch the accepted item, arm the remainder unit
    logic mod_step;   // one step of the top row remainder
    logic exec;       // perform the item's main action
    logic sweep_run;  // write zero at the sweep address and advance
    logic sweep_row;  // sweep one storage row instead of the whole screen
    logic out_load;   // capture the result
  } cmd_t;

  typedef struct packed {
    logic       top_big;
    logic       mod_last;
    logic [1:0] mode;
    logic       need_scroll;
    logic       sweep_last_all;
    logic       sweep_last_row;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_scroll.sv =====
// text_console_cursor_scroll: top level of the text console
// joins tccs_ctrl and tccs_dp, packs the stream ports; uses tccs_pkg
`timescale 1ns / 1ps
`default_nettype none

// Text console with a cursor: each input item puts a character, reads one
// cell or clears the screen, and gives exactly one result with the cursor
// position afterwards. A put, a read or an unused mode goes through accept,
// execute and result; the result step waits while the output is stalled.
// When the screen height has been lowered to or below the stored top-row
// ring pointer, the pointer is first reduced by a bit-serial remainder unit
// that handles one row-index bit per step. A put that scrolls clears one
// storage row through the single memory write port, and a clear walks the
// whole memory. After reset a clearing pass over the whole memory runs with
// s_axis_tready low; configuration writes are taken at any time and should
// only be made while the block is idle.
module text_console_cursor_scroll #(
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tccs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // char_code[7:0], read_row[12:8], read_column[19:13], zero[23:20]
  input  logic [tccs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [tccs_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_char[7:0], cursor_row_now[12:8], cursor_column_now[19:13],
  // did_scroll[20], zero[23:21]
  output logic [tccs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import tccs_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] cell_char;
  logic [4:0] cursor_row_now;
  logic [6:0] cursor_column_now;
  logic       did_scroll;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tccs_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (s_axis_tuser[1:0]),
    .char_code         (s_axis_tdata[7:0]),
    .read_row          (s_axis_tdata[12:8]),
    .read_column       (s_axis_tdata[19:13]),
    .cell_char         (cell_char),
    .cursor_row_now    (cursor_row_now),
    .cursor_column_now (cursor_column_now),
    .did_scroll        (did_scroll)
  );

  assign m_axis_tdata = {3'b000, did_scroll, cursor_column_now, cursor_row_now, cell_char};

`ifndef SYNTHESIS
  // no item is taken while the memory is being cleared
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cmd.sweep_run)
    else $error("input ready while a clear sweep runs");

  // the controller issues one kind of command at a time
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mod_step, cmd.exec, cmd.sweep_run, cmd.out_load}))
    else $error("overlapping datapath commands");

  // a captured result is offered on the next cycle
  a_result_offered: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_axis_tvalid)
    else $error("result captured but not offered");
`endif

endmodule

`default_nettype wire

// ===== rtl/tccs_ram.sv =====
// tccs_ram: generic single write port, single read port memory
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/tccs_ctrl.sv =====
// tccs_ctrl: sequencing state machine of the text console
// drives datapath commands from its status; uses tccs_pkg
`timescale 1ns / 1ps
`default_nettype none

module tccs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output tccs_pkg::cmd_t  cmd,
  input  tccs_pkg::stat_t stat
);

  import tccs_pkg::*;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_MOD    = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_last_all) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.top_big ? S_MOD : S_EXEC;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.mode)
          MODE_PUT:   state_next = stat.need_scroll ? S_SCROLL : S_DONE;
          MODE_CLEAR: state_next = S_CLEAR;
          default:    state_next = S_DONE;
        endcase
      end
      S_SCROLL: begin
        cmd.sweep_run = 1'b1;
        cmd.sweep_row = 1'b1;
        if (stat.sweep_last_row) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_last_all) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tccs_dp.sv =====
// tccs_dp: datapath of the text console: size registers, cursor, ring
// pointer, remainder unit, clear sweep and the screen memory
// uses tccs_pkg and tccs_ram
`timescale 1ns / 1ps
`default_nettype none

module tccs_dp #(
  parameter int MAX_ROWS    = tccs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = tccs_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tccs_pkg::cmd_t                   cmd,
  output tccs_pkg::stat_t                  stat,
  input  logic                             cfg_write,
  input  logic [tccs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                       mode,
  input  logic [7:0]                       char_code,
  input  logic [4:0]                       read_row,
  input  logic [6:0]                       read_column,
  output logic [7:0]                       cell_char,
  output logic [4:0]                       cursor_row_now,
  output logic [6:0]                       cursor_column_now,
  output logic                             did_scroll
);

  import tccs_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int NW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int MW  = $clog2(MAX_COLUMNS + 1);
  localparam int AW  = RW + CW;
  localparam int RW1 = RW + 1;
  localparam int NW1 = NW + 1;
  localparam int CNW = $clog2(RW + 1);

  logic [5:0]    screen_rows;
  logic [7:0]    screen_columns;
  logic [NW-1:0] rows_eff;
  logic [MW-1:0] cols_eff;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] cols_m1;

  logic [1:0]    in_mode;
  logic [7:0]    in_char;
  logic [4:0]    in_row;
  logic [6:0]    in_col;

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] top_row;
  logic [RW-1:0] scroll_row;
  logic          scrolled;

  logic [NW:0]    rem, rem_next, rem_sh;
  logic [RW-1:0]  dvd;
  logic [CNW-1:0] mcnt;

  logic [AW-1:0] sweep;

  logic          top_big;
  logic [RW-1:0] t_eff;
  logic [RW-1:0] row_c, new_row, top_next;
  logic [CW-1:0] col_c, new_col;
  logic [MW-1:0] col_inc;
  logic          is_lf, is_cr, wrap_col, row_adv, need_scroll;
  logic [RW-1:0] p_put, p_read;
  logic          read_hit;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // (a + b) mod n where a and b are both below n
  function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a,
                                              input logic [RW-1:0] b,
                                              input logic [NW-1:0] n);
    logic [RW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= RW1'(n)) begin
      s = s - RW1'(n);
    end
    return s[RW-1:0];
  endfunction

  // effective screen size, limited to 1..max
  always_comb begin
    if (screen_rows == '0) begin
      rows_eff = NW'(1);
    end else if (int'(screen_rows) > MAX_ROWS) begin
      rows_eff = NW'(MAX_ROWS);
    end else begin
      rows_eff = NW'(screen_rows);
    end
    if (screen_columns == '0) begin
      cols_eff = MW'(1);
    end else if (int'(screen_columns) > MAX_COLUMNS) begin
      cols_eff = MW'(MAX_COLUMNS);
    end else begin
      cols_eff = MW'(screen_columns);
    end
  end

  assign rows_m1 = RW'(rows_eff - NW'(1));
  assign cols_m1 = CW'(cols_eff - MW'(1));

  // ring pointer reduced below the row count
  assign top_big = NW'(top_row) >= rows_eff;
  assign t_eff   = top_big ? RW'(rem) : top_row;

  // put: clamp the cursor, then move it
  assign row_c    = (NW'(cur_row) >= rows_eff) ? rows_m1 : cur_row;
  assign col_c    = (MW'(cur_col) >= cols_eff) ? cols_m1 : cur_col;
  assign is_lf    = (in_char == CHAR_LF);
  assign is_cr    = (in_char == CHAR_CR);
  assign col_inc  = MW'(col_c) + MW'(1);
  assign wrap_col = (col_inc >= cols_eff);
  assign row_adv  = is_lf || (!is_cr && wrap_col);
  assign need_scroll = row_adv && (row_c == rows_m1);
  assign new_col  = (is_lf || is_cr || wrap_col) ? '0 : CW'(col_inc);
  assign new_row  = row_adv ? (need_scroll ? rows_m1 : row_c + RW'(1)) : row_c;
  assign top_next = (t_eff == rows_m1) ? '0 : t_eff + RW'(1);
  assign p_put    = ring_add(t_eff, row_c, rows_eff);

  // read address
  assign read_hit  = (int'(in_row) < int'(rows_eff)) && (int'(in_col) < int'(cols_eff));
  assign p_read    = ring_add(t_eff, RW'(in_row), rows_eff);
  assign ram_raddr = {p_read, CW'(in_col)};

  // remainder step
  assign rem_sh   = {rem[NW-1:0], dvd[RW-1]};
  assign rem_next = (rem_sh >= NW1'(rows_eff)) ? rem_sh - NW1'(rows_eff) : rem_sh;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_raddr;
    ram_wdata = '0;
    if (cmd.sweep_run) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.sweep_row ? {scroll_row, sweep[CW-1:0]} : sweep;
    end else if (cmd.exec && in_mode == MODE_PUT && !is_lf && !is_cr) begin
      ram_we    = 1'b1;
      ram_waddr = {p_put, col_c};
      ram_wdata = in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows    <= SCREEN_ROWS_RESET;
      screen_columns <= SCREEN_COLUMNS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_ROWS:    screen_rows    <= cfg_data[5:0];
        REG_SCREEN_COLUMNS: screen_columns <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      top_row <= '0;
      sweep   <= '0;
      mcnt    <= '0;
    end else begin
      sweep <= cmd.sweep_run ? sweep + AW'(1) : '0;
      if (cmd.load) begin
        mcnt <= CNW'(RW);
      end else if (cmd.mod_step) begin
        mcnt <= mcnt - CNW'(1);
      end
      if (cmd.exec) begin
        unique case (in_mode)
          MODE_PUT: begin
            cur_row <= new_row;
            cur_col <= new_col;
            if (need_scroll) begin
              top_row <= top_next;
            end
          end
          MODE_CLEAR: begin
            cur_row <= '0;
            cur_col <= '0;
            top_row <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // item payload, remainder unit and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mode  <= mode;
      in_char  <= char_code;
      in_row   <= read_row;
      in_col   <= read_column;
      rem      <= '0;
      dvd      <= top_row;
      scrolled <= 1'b0;
    end else if (cmd.mod_step) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end else if (cmd.exec) begin
      scrolled   <= (in_mode == MODE_PUT) && need_scroll;
      scroll_row <= t_eff;
    end
    if (cmd.out_load) begin
      cell_char         <= (in_mode == MODE_READ && read_hit) ? ram_rdata : '0;
      cursor_row_now    <= 5'(cur_row);
      cursor_column_now <= 7'(cur_col);
      did_scroll        <= scrolled;
    end
  end

  assign stat.top_big        = top_big;
  assign stat.mod_last       = (mcnt == CNW'(1));
  assign stat.mode           = in_mode;
  assign stat.need_scroll    = need_scroll;
  assign stat.sweep_last_all = &sweep;
  assign stat.sweep_last_row = &sweep[CW-1:0];

  tccs_ram #(
    .WIDTH (8),
    .DEPTH (2 ** AW)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
